// ===== src/fpq_pkg.sv =====
// ----------------------------------------------------------------------------
// fpq_pkg
// Shared types, codes and defaults for the five-level priority queue.
// ----------------------------------------------------------------------------
package fpq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int LEVELS_DEF   = 5;
  localparam int TAG_BITS_DEF = 16;

  localparam int TAG_W   = 16;
  localparam int LEVEL_W = 3;

  // Request kinds
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_SERVE = 2'd1;
  localparam logic [1:0] KIND_LIST  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_ADDED      = 3'd0;
  localparam logic [2:0] ST_DROPPED    = 3'd1;
  localparam logic [2:0] ST_SERVED     = 3'd2;
  localparam logic [2:0] ST_SERVE_NONE = 3'd3;
  localparam logic [2:0] ST_LISTED     = 3'd4;
  localparam logic [2:0] ST_LIST_EMPTY = 3'd5;

  typedef struct packed {
    logic [1:0]         kind;
    logic [LEVEL_W-1:0] level;
    logic [TAG_W-1:0]   tag;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [TAG_W-1:0]   out_tag;
    logic [LEVEL_W-1:0] out_level;
    logic               last;
  } out_rsp_t;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic     load;
    out_rsp_t rsp;
  } res_push_t;

endpackage

// ===== src/five_level_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// five_level_priority_queue_top
// Bounded strict-priority queue, first in first out within each level.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready with in_req (kind, level, tag);
// results leave on out_valid/out_ready with out_rsp (status, out_tag,
// out_level, last). Entries live in one RAM, kept sorted in service order.
// An add walks from the tail toward its insertion point, one entry per
// cycle through the RAM read-modify-write loop.
// A serve reads the head and moves every other entry up by one slot.
// A list streams one entry per cycle while the receiver accepts, after a
// registered RAM read, marking the final entry with last. Drops, empty
// serves, empty lists and adds into an empty queue answer in the cycle
// the request is taken. One request is handled at a time; the next one is
// taken once the previous result has been produced and the output register
// is free. Results sit in an output register; when the receiver stalls,
// the block holds its finished result and listing pauses without losing entries.
// Reset (synchronous, active low) empties the queue; no clearing pass runs.
// ----------------------------------------------------------------------------
module five_level_priority_queue_top #(
  parameter int CAPACITY = fpq_pkg::CAPACITY_DEF,
  parameter int LEVELS   = fpq_pkg::LEVELS_DEF,
  parameter int TAG_BITS = fpq_pkg::TAG_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fpq_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output fpq_pkg::out_rsp_t out_rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SW = (TAG_BITS < fpq_pkg::TAG_W) ? TAG_BITS : fpq_pkg::TAG_W;
  localparam int EW = SW + fpq_pkg::LEVEL_W;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [EW-1:0]      wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [EW-1:0]      rd_data;
  logic               out_free;
  fpq_pkg::res_push_t res;

  logic               out_valid_r, out_valid_nxt;
  fpq_pkg::out_rsp_t  out_rsp_r, out_rsp_nxt;

  assign out_free = !out_valid_r || out_ready;

  fpq_ctrl #(
    .CAPACITY (CAPACITY),
    .LEVELS   (LEVELS),
    .TAG_BITS (TAG_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_req   (in_req),
    .in_ready (in_ready),
    .out_free (out_free),
    .res      (res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  fpq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_rsp_nxt   = out_rsp_r;
    if (res.load) begin
      out_valid_nxt = 1'b1;
      out_rsp_nxt   = res.rsp;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// ===== src/fpq_ram.sv =====
// ----------------------------------------------------------------------------
// fpq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/fpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpq_ctrl
// Sequencer that keeps the entry memory sorted in service order and walks it
// for add, serve and list requests.
// ----------------------------------------------------------------------------
module fpq_ctrl #(
  parameter int CAPACITY = fpq_pkg::CAPACITY_DEF,
  parameter int LEVELS   = fpq_pkg::LEVELS_DEF,
  parameter int TAG_BITS = fpq_pkg::TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  fpq_pkg::in_req_t    in_req,
  output logic                in_ready,
  input  logic                out_free,
  output fpq_pkg::res_push_t  res,
  output logic                                               wr_en,
  output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0]   wr_addr,
  output logic [((TAG_BITS < fpq_pkg::TAG_W) ? TAG_BITS : fpq_pkg::TAG_W)
                + fpq_pkg::LEVEL_W - 1:0]                    wr_data,
  output logic                                               rd_en,
  output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0]   rd_addr,
  input  logic [((TAG_BITS < fpq_pkg::TAG_W) ? TAG_BITS : fpq_pkg::TAG_W)
                + fpq_pkg::LEVEL_W - 1:0]                    rd_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = $clog2(CAPACITY + 1);
  localparam int SW = (TAG_BITS < fpq_pkg::TAG_W) ? TAG_BITS : fpq_pkg::TAG_W;
  localparam int LW = fpq_pkg::LEVEL_W;
  localparam int EW = SW + LW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_ADD_HEAD,
    S_SRV_HEAD,
    S_SRV_SHIFT,
    S_LIST,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [OW-1:0]       occ_r, occ_nxt;
  logic [SW-1:0]       hold_tag_r, hold_tag_nxt;
  logic [LW-1:0]       hold_level_r, hold_level_nxt;
  fpq_pkg::out_rsp_t   pend_r, pend_nxt;

  logic                accept;
  logic [SW-1:0]       rd_tag;
  logic [LW-1:0]       rd_level;
  logic                bad_level;
  logic                idx_is_last;

  function automatic fpq_pkg::out_rsp_t make_rsp(input logic [2:0] status,
                                                 input logic [SW-1:0] tag,
                                                 input logic [LW-1:0] level,
                                                 input logic last);
    fpq_pkg::out_rsp_t r;
    r           = '0;
    r.status    = status;
    r.out_tag[SW-1:0] = tag;
    r.out_level = level;
    r.last      = last;
    return r;
  endfunction

  assign rd_tag      = rd_data[SW-1:0];
  assign rd_level    = rd_data[EW-1:SW];
  assign bad_level   = ({1'b0, in_req.level} >= (LW + 1)'(LEVELS));
  assign idx_is_last = ((OW'(idx_r) + OW'(1)) == occ_r);

  // New requests wait until any earlier result has left and the slot is free,
  // so that a single-result request can complete on the cycle it is taken.
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    occ_nxt        = occ_r;
    hold_tag_nxt   = hold_tag_r;
    hold_level_nxt = hold_level_r;
    pend_nxt       = pend_r;
    res            = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_req.kind)
            fpq_pkg::KIND_ADD: begin
              if (bad_level || (occ_r == OW'(CAPACITY))) begin
                res.load = 1'b1;
                res.rsp  = make_rsp(fpq_pkg::ST_DROPPED, '0, '0, 1'b1);
              end else if (occ_r == '0) begin
                wr_en    = 1'b1;
                wr_addr  = '0;
                wr_data  = {in_req.level, in_req.tag[SW-1:0]};
                occ_nxt  = OW'(1);
                res.load = 1'b1;
                res.rsp  = make_rsp(fpq_pkg::ST_ADDED, '0, '0, 1'b1);
              end else begin
                // Walk from the tail toward the head, moving each less
                // urgent entry one slot down until the insertion point.
                hold_tag_nxt   = in_req.tag[SW-1:0];
                hold_level_nxt = in_req.level;
                idx_nxt        = AW'(occ_r - OW'(1));
                rd_en          = 1'b1;
                rd_addr        = AW'(occ_r - OW'(1));
                state_nxt      = S_ADD_SCAN;
              end
            end
            fpq_pkg::KIND_SERVE: begin
              if (occ_r == '0) begin
                res.load = 1'b1;
                res.rsp  = make_rsp(fpq_pkg::ST_SERVE_NONE, '0, '0, 1'b1);
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_SRV_HEAD;
              end
            end
            fpq_pkg::KIND_LIST: begin
              if (occ_r == '0) begin
                res.load = 1'b1;
                res.rsp  = make_rsp(fpq_pkg::ST_LIST_EMPTY, '0, '0, 1'b1);
              end else begin
                idx_nxt   = '0;
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_ADD_SCAN: begin
        wr_en   = 1'b1;
        wr_addr = idx_r + AW'(1);
        if (rd_level > hold_level_r) begin
          wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = S_ADD_HEAD;
          end else begin
            idx_nxt = idx_r - AW'(1);
            rd_en   = 1'b1;
            rd_addr = idx_r - AW'(1);
          end
        end else begin
          wr_data   = {hold_level_r, hold_tag_r};
          occ_nxt   = occ_r + OW'(1);
          pend_nxt  = make_rsp(fpq_pkg::ST_ADDED, '0, '0, 1'b1);
          state_nxt = S_DONE;
        end
      end

      S_ADD_HEAD: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = {hold_level_r, hold_tag_r};
        occ_nxt   = occ_r + OW'(1);
        pend_nxt  = make_rsp(fpq_pkg::ST_ADDED, '0, '0, 1'b1);
        state_nxt = S_DONE;
      end

      S_SRV_HEAD: begin
        pend_nxt = make_rsp(fpq_pkg::ST_SERVED, rd_tag, rd_level, 1'b1);
        if (occ_r == OW'(1)) begin
          occ_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = AW'(1);
          rd_en     = 1'b1;
          rd_addr   = AW'(1);
          state_nxt = S_SRV_SHIFT;
        end
      end

      S_SRV_SHIFT: begin
        // Each entry moves one slot toward the head.
        wr_en   = 1'b1;
        wr_addr = idx_r - AW'(1);
        wr_data = rd_data;
        if (idx_is_last) begin
          occ_nxt   = occ_r - OW'(1);
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + AW'(1);
          rd_en   = 1'b1;
          rd_addr = idx_r + AW'(1);
        end
      end

      S_LIST: begin
        // The read data holds while the receiver stalls, since no new read
        // is issued until this entry goes out.
        if (out_free) begin
          res.load = 1'b1;
          res.rsp  = make_rsp(fpq_pkg::ST_LISTED, rd_tag, rd_level, idx_is_last);
          if (idx_is_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + AW'(1);
            rd_en   = 1'b1;
            rd_addr = idx_r + AW'(1);
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          res.load  = 1'b1;
          res.rsp   = pend_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      idx_r   <= idx_nxt;
    end
    hold_tag_r   <= hold_tag_nxt;
    hold_level_r <= hold_level_nxt;
    pend_r       <= pend_nxt;
  end

endmodule
